>>> src/isd_pkg.sv
package isd_pkg;

	// characters of interest in the leading run
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;

	// configuration register indexes
	localparam logic [1:0] REG_MIN_INDENT = 2'd0;
	localparam logic [1:0] REG_MAX_INDENT = 2'd1;
	localparam logic [1:0] REG_MAX_LINES  = 2'd2;

	// configuration reset values
	localparam logic [7:0]  MIN_INDENT_RST = 8'd2;
	localparam logic [7:0]  MAX_INDENT_RST = 8'd8;
	localparam logic [15:0] MAX_LINES_RST  = 16'd500;

	// tab style codes
	localparam logic [1:0] STYLE_UNKNOWN = 2'd0;
	localparam logic [1:0] STYLE_TABS    = 2'd1;
	localparam logic [1:0] STYLE_SPACES  = 2'd2;

	// line-end sequencer
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_BUMP  = 4'b0010,
		ST_SWEEP = 4'b0100,
		ST_OUT   = 4'b1000
	} isd_state_t;

	// summary of the current line, including the word being accepted
	typedef struct packed {
		logic        saw_tab;
		logic        skip;
		logic        has_content;
		logic [15:0] lead_spaces;
	} isd_line_t;

endpackage

>>> src/isd_scan.sv
module isd_scan
	import isd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] text_byte,
	input  logic       has_byte,
	input  logic       end_of_line,
	output isd_line_t  line
);

	logic        in_run_q;
	logic        saw_tab_q;
	logic        skip_q;
	logic        content_q;
	logic [15:0] spaces_q;

	logic        in_run_d;
	logic        saw_tab_d;
	logic        skip_d;
	logic        content_d;
	logic [15:0] spaces_d;

	// leading-run scan of one byte
	always_comb begin
		in_run_d  = in_run_q;
		saw_tab_d = saw_tab_q;
		skip_d    = skip_q;
		content_d = content_q;
		spaces_d  = spaces_q;
		if (has_byte) begin
			if (text_byte != CH_CR && text_byte != CH_LF) begin
				content_d = 1'b1;
			end
			if (in_run_q) begin
				case (text_byte)
					CH_TAB: begin
						saw_tab_d = 1'b1;
						if (spaces_q != 16'd0) begin
							skip_d   = 1'b1;
							in_run_d = 1'b0;
						end
					end
					CH_SPACE: begin
						if (spaces_q != 16'hFFFF) begin
							spaces_d = spaces_q + 16'd1;
						end
						if (saw_tab_q) begin
							skip_d   = 1'b1;
							in_run_d = 1'b0;
						end
					end
					CH_STAR: begin
						skip_d   = 1'b1;
						in_run_d = 1'b0;
					end
					default: begin
						in_run_d = 1'b0;
					end
				endcase
			end
		end
	end

	assign line.saw_tab     = saw_tab_d;
	assign line.skip        = skip_d;
	assign line.has_content = content_d;
	assign line.lead_spaces = spaces_d;

	// per-line state; cleared when the line closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q  <= 1'b1;
			saw_tab_q <= 1'b0;
			skip_q    <= 1'b0;
			content_q <= 1'b0;
			spaces_q  <= 16'd0;
		end else if (take) begin
			if (end_of_line) begin
				in_run_q  <= 1'b1;
				saw_tab_q <= 1'b0;
				skip_q    <= 1'b0;
				content_q <= 1'b0;
				spaces_q  <= 16'd0;
			end else begin
				in_run_q  <= in_run_d;
				saw_tab_q <= saw_tab_d;
				skip_q    <= skip_d;
				content_q <= content_d;
				spaces_q  <= spaces_d;
			end
		end
	end

endmodule

>>> src/isd_hist.sv
module isd_hist #(
	parameter int BINS = 8,
	parameter int CW   = 32,
	parameter int AW   = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [CW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [CW-1:0] wr_data
);

	logic [CW-1:0]   hist_mem_q [BINS];
	logic [CW-1:0]   rd_data_q;
	logic [BINS-1:0] valid_q;
	logic            rd_valid_q;

	// histogram storage, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= hist_mem_q[rd_addr];
		end
	end

	// per-bin valid bits stand in for clearing the array on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

>>> src/indent_style_detector_core.sv
// Indent style detector.
// A word without end_of_line leaves the block ready; the next word may follow at once.
// A word with end_of_line makes the block busy: one read-modify-write of a
// histogram bin, then a sweep reading one bin a cycle, then the result load.
// Asynchronous active-low reset clears all counters, the histogram valid
// bits and the line state; registers return to 2, 8 and 500.
module indent_style_detector_core
	import isd_pkg::*;
#(
	parameter int HIST_BINS   = 8,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        has_byte,
	input  logic        end_of_line,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        keep_going,
	output logic [1:0]  tab_style,
	output logic [7:0]  indent_size,
	output logic [31:0] lines_seen,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW = COUNT_WIDTH;
	localparam int AW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
	localparam int SW = $clog2(HIST_BINS + 1);

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	isd_state_t state_q;

	logic [7:0]    min_indent_q;
	logic [7:0]    max_indent_q;
	logic [15:0]   max_lines_q;

	logic [CW-1:0] line_total_q;
	logic [CW-1:0] thresh_total_q;
	logic [CW-1:0] tab_total_q;
	logic [CW-1:0] space_total_q;
	logic [15:0]   prev_indent_q;

	logic [AW-1:0] bin_q;
	logic          hit_q;
	logic [SW-1:0] sweep_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [CW-1:0] best_val_q;
	logic [7:0]    best_pos_q;

	logic          out_valid_q;
	logic          keep_going_q;
	logic [1:0]    tab_style_q;
	logic [7:0]    indent_size_q;
	logic [31:0]   lines_seen_q;

	logic          in_fire;
	logic          out_free;
	isd_line_t     line;

	logic [15:0]   delta;
	logic [15:0]   delta_off;
	logic          hist_hit;

	logic          hist_rd_en;
	logic [AW-1:0] hist_rd_addr;
	logic [CW-1:0] hist_rd_data;
	logic          hist_we;

	logic          sweep_issue;
	logic [8:0]    sweep_pos;
	logic          sweep_in_range;
	logic [CW+3:0] bin_x10;
	logic          sweep_take;
	logic [1:0]    style_now;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	isd_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (in_fire),
		.text_byte   (text_byte),
		.has_byte    (has_byte),
		.end_of_line (end_of_line),
		.line        (line)
	);

	isd_hist #(
		.BINS (HIST_BINS),
		.CW   (CW),
		.AW   (AW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (hist_rd_en),
		.rd_addr (hist_rd_addr),
		.rd_data (hist_rd_data),
		.wr_en   (hist_we),
		.wr_addr (bin_q),
		.wr_data (sat_inc(hist_rd_data))
	);

	// indent change against the last unskipped, tab-free content line and its bin
	always_comb begin
		delta     = (line.lead_spaces >= prev_indent_q) ? line.lead_spaces - prev_indent_q
			: prev_indent_q - line.lead_spaces;
		delta_off = delta - {8'd0, min_indent_q};
		hist_hit  = !line.skip && !line.saw_tab && line.has_content
			&& (delta >= {8'd0, min_indent_q}) && (delta <= {8'd0, max_indent_q})
			&& (delta_off < 16'(HIST_BINS));
	end

	// histogram port: bin read at line close, then one bin a cycle in the sweep
	assign sweep_issue  = (state_q == ST_SWEEP) && (sweep_q < SW'(HIST_BINS));
	assign hist_rd_en   = (in_fire && end_of_line) || sweep_issue;
	assign hist_rd_addr = sweep_issue ? sweep_q[AW-1:0] : delta_off[AW-1:0];
	assign hist_we      = (state_q == ST_BUMP) && hit_q;

	// sweep compare: count > threshold/10 is the same as 10*count > threshold
	always_comb begin
		sweep_pos      = {1'b0, min_indent_q} + 9'(rd_idx_s1);
		sweep_in_range = sweep_pos <= {1'b0, max_indent_q};
		bin_x10        = ((CW+4)'(hist_rd_data) << 3) + ((CW+4)'(hist_rd_data) << 1);
		sweep_take     = rd_vld_s1 && sweep_in_range && (hist_rd_data > best_val_q)
			&& (bin_x10 > (CW+4)'(thresh_total_q));
	end

	always_comb begin
		if (tab_total_q > space_total_q) begin
			style_now = STYLE_TABS;
		end else if (space_total_q > tab_total_q) begin
			style_now = STYLE_SPACES;
		end else begin
			style_now = STYLE_UNKNOWN;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_indent_q <= MIN_INDENT_RST;
			max_indent_q <= MAX_INDENT_RST;
			max_lines_q  <= MAX_LINES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_INDENT: min_indent_q <= cfg_data[7:0];
				REG_MAX_INDENT: max_indent_q <= cfg_data[7:0];
				REG_MAX_LINES:  max_lines_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// line totals, updated as the line closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_total_q   <= '0;
			thresh_total_q <= '0;
			tab_total_q    <= '0;
			space_total_q  <= '0;
			prev_indent_q  <= 16'd0;
			bin_q          <= '0;
			hit_q          <= 1'b0;
		end else if (in_fire && end_of_line) begin
			line_total_q <= sat_inc(line_total_q);
			bin_q        <= delta_off[AW-1:0];
			hit_q        <= hist_hit;
			if (!line.skip) begin
				if (line.saw_tab) begin
					tab_total_q    <= sat_inc(tab_total_q);
					thresh_total_q <= sat_inc(thresh_total_q);
				end else begin
					if (line.lead_spaces != 16'd0) begin
						space_total_q <= sat_inc(space_total_q);
					end
					if (line.has_content) begin
						prev_indent_q <= line.lead_spaces;
					end
					if (hist_hit) begin
						thresh_total_q <= sat_inc(thresh_total_q);
					end
				end
			end
		end
	end

	// line-end sequencer and sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sweep_q    <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			best_val_q <= '0;
			best_pos_q <= 8'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && end_of_line) begin
						state_q <= ST_BUMP;
					end
				end
				ST_BUMP: begin
					sweep_q    <= '0;
					rd_vld_s1  <= 1'b0;
					best_val_q <= '0;
					best_pos_q <= 8'd0;
					state_q    <= ST_SWEEP;
				end
				ST_SWEEP: begin
					rd_vld_s1 <= sweep_issue;
					rd_idx_s1 <= sweep_q[AW-1:0];
					if (sweep_issue) begin
						sweep_q <= sweep_q + 1'b1;
					end
					if (sweep_take) begin
						best_val_q <= hist_rd_data;
						best_pos_q <= sweep_pos[7:0];
					end
					if (rd_vld_s1 && rd_idx_s1 == AW'(HIST_BINS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			keep_going_q  <= line_total_q < CW'(max_lines_q);
			tab_style_q   <= style_now;
			indent_size_q <= best_pos_q;
			lines_seen_q  <= ((line_total_q >> 32) != '0) ? 32'hFFFF_FFFF
				: 32'(line_total_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign keep_going  = keep_going_q;
	assign tab_style   = tab_style_q;
	assign indent_size = indent_size_q;
	assign lines_seen  = lines_seen_q;

	// checks
	a_bump_follows_close: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BUMP |-> $past(in_valid && in_ready && end_of_line))
		else $error("bin update without a closed line");

	a_sweep_data_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == ST_SWEEP)
		else $error("sweep read data outside the sweep");

	a_thresh_covers_tabs: assert property (@(posedge clk) disable iff (!arst_n)
		thresh_total_q >= tab_total_q)
		else $error("threshold total below tab line total");

	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && (!out_valid || out_ready) |=> out_valid)
		else $error("result not presented after sweep");

	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		hist_we |-> !sweep_issue && !rd_vld_s1)
		else $error("histogram write overlaps the sweep");

endmodule

>>> test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import isd_pkg::*;

	localparam int BINS        = 8;
	localparam int SETTLE      = 20;   // covers the line-end sequence
	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AFTER  = 20;

	// index with no register behind it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic        keep_going;
		logic [1:0]  tab_style;
		logic [7:0]  indent_size;
		logic [31:0] lines_seen;
	} report_t;

	typedef struct packed {
		logic    valid;
		report_t report;
	} preset_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       has_byte;
		logic       end_of_line;
		logic       typed;
		report_t    report;
	} opening_row_t;

	// opening words; the report is typed in only where it is obvious
	localparam opening_row_t OPENING [22] = '{
		'{8'h00,    1'b0, 1'b1, 1'b1, '{1'b1, STYLE_UNKNOWN, 8'd0, 32'd1}},
		'{8'hFF,    1'b0, 1'b0, 1'b0, '0},
		'{CH_TAB,   1'b1, 1'b0, 1'b0, '0},
		'{8'h61,    1'b1, 1'b1, 1'b1, '{1'b1, STYLE_TABS, 8'd0, 32'd2}},
		'{CH_SPACE, 1'b1, 1'b0, 1'b0, '0},
		'{CH_SPACE, 1'b1, 1'b0, 1'b0, '0},
		'{CH_SPACE, 1'b1, 1'b0, 1'b0, '0},
		'{CH_SPACE, 1'b1, 1'b0, 1'b0, '0},
		'{8'h78,    1'b1, 1'b1, 1'b0, '0},
		'{CH_SPACE, 1'b1, 1'b0, 1'b0, '0},
		'{CH_TAB,   1'b1, 1'b1, 1'b0, '0},
		'{CH_TAB,   1'b1, 1'b0, 1'b0, '0},
		'{CH_SPACE, 1'b1, 1'b1, 1'b0, '0},
		'{CH_SPACE, 1'b1, 1'b0, 1'b0, '0},
		'{CH_SPACE, 1'b1, 1'b0, 1'b0, '0},
		'{CH_STAR,  1'b1, 1'b1, 1'b0, '0},
		'{CH_CR,    1'b1, 1'b0, 1'b0, '0},
		'{CH_LF,    1'b1, 1'b1, 1'b0, '0},
		'{8'h00,    1'b1, 1'b1, 1'b0, '0},
		'{CH_SPACE, 1'b1, 1'b0, 1'b0, '0},
		'{CH_SPACE, 1'b1, 1'b1, 1'b0, '0},
		'{8'hFF,    1'b1, 1'b1, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  text_byte;
	logic        has_byte;
	logic        end_of_line;
	logic        out_valid;
	logic        out_ready;
	logic        keep_going;
	logic [1:0]  tab_style;
	logic [7:0]  indent_size;
	logic [31:0] lines_seen;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// predicted line statistics
	logic [31:0] line_total;
	logic [31:0] threshold_total;
	logic [31:0] tab_lines;
	logic [31:0] space_lines;
	logic [15:0] previous_indent;
	logic [31:0] change_bins [BINS];
	logic        in_run;
	logic        saw_tab;
	logic [15:0] lead_spaces;
	logic        skip_line;
	logic        has_content;
	logic [7:0]  min_indent;
	logic [7:0]  max_indent;
	logic [15:0] line_limit;

	report_t expected_reports [$];
	preset_t preset_reports [$];
	int      mismatches   = 0;
	int      results_seen = 0;
	int      word_count   = 0;
	int      indent_step  = 2;
	bit      tx_calm      = 1'b0;

	indent_style_detector_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.has_byte    (has_byte),
		.end_of_line (end_of_line),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.keep_going  (keep_going),
		.tab_style   (tab_style),
		.indent_size (indent_size),
		.lines_seen  (lines_seen),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] bump(input logic [31:0] count);
		return (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
	endfunction

	function automatic void clear_line_state();
		in_run      = 1'b1;
		saw_tab     = 1'b0;
		lead_spaces = '0;
		skip_line   = 1'b0;
		has_content = 1'b0;
	endfunction

	function automatic void model_reset();
		line_total      = '0;
		threshold_total = '0;
		tab_lines       = '0;
		space_lines     = '0;
		previous_indent = '0;
		for (int i = 0; i < BINS; i++)
			change_bins[i] = '0;
		clear_line_state();
		min_indent = MIN_INDENT_RST;
		max_indent = MAX_INDENT_RST;
		line_limit = MAX_LINES_RST;
	endfunction

	// leading-run scan of one character
	function automatic void scan_char(input logic [7:0] ch);
		if (ch != CH_CR && ch != CH_LF)
			has_content = 1'b1;
		if (in_run) begin
			if (ch == CH_TAB) begin
				saw_tab = 1'b1;
				if (lead_spaces != 0) begin
					skip_line = 1'b1;
					in_run    = 1'b0;
				end
			end else if (ch == CH_SPACE) begin
				if (lead_spaces != 16'hFFFF)
					lead_spaces++;
				if (saw_tab) begin
					skip_line = 1'b1;
					in_run    = 1'b0;
				end
			end else if (ch == CH_STAR) begin
				skip_line = 1'b1;
				in_run    = 1'b0;
			end else begin
				in_run = 1'b0;
			end
		end
	endfunction

	// line-end bookkeeping: style totals and indent-change histogram
	function automatic void close_line();
		int unsigned change;
		if (!skip_line) begin
			if (saw_tab) begin
				tab_lines       = bump(tab_lines);
				threshold_total = bump(threshold_total);
			end else begin
				if (lead_spaces != 0)
					space_lines = bump(space_lines);
				if (has_content) begin
					change = (lead_spaces >= previous_indent) ?
						lead_spaces - previous_indent : previous_indent - lead_spaces;
					previous_indent = lead_spaces;
					if (change >= min_indent && change <= max_indent &&
							change - min_indent < BINS) begin
						change_bins[change - min_indent] = bump(change_bins[change - min_indent]);
						threshold_total = bump(threshold_total);
					end
				end
			end
		end
		line_total = bump(line_total);
		clear_line_state();
	endfunction

	// first bin with the strictly largest count above a tenth of the threshold
	function automatic logic [7:0] pick_indent_size();
		logic [31:0] floor_count;
		logic [31:0] best_count;
		int          best_pos;
		floor_count = threshold_total / 10;
		best_count  = '0;
		best_pos    = 0;
		for (int i = 0; i < BINS; i++) begin
			if (int'(min_indent) + i > int'(max_indent))
				break;
			if (change_bins[i] > best_count && change_bins[i] > floor_count) begin
				best_pos   = int'(min_indent) + i;
				best_count = change_bins[i];
			end
		end
		return best_pos[7:0];
	endfunction

	function automatic bit absorb_word(input logic [7:0] ch, input logic has,
			input logic eol, output report_t rpt);
		if (has)
			scan_char(ch);
		if (!eol)
			return 1'b0;
		close_line();
		rpt.keep_going = (line_total < line_limit);
		if (tab_lines > space_lines)
			rpt.tab_style = STYLE_TABS;
		else if (space_lines > tab_lines)
			rpt.tab_style = STYLE_SPACES;
		else
			rpt.tab_style = STYLE_UNKNOWN;
		rpt.indent_size = pick_indent_size();
		rpt.lines_seen  = line_total;
		return 1'b1;
	endfunction

	task automatic check_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
		end
	endtask

	// track accepted words and register writes, check accepted results
	always @(posedge clk) begin
		preset_t preset;
		report_t predicted;
		report_t want;
		if (!arst_n) begin
			model_reset();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_INDENT: min_indent = cfg_data[7:0];
					REG_MAX_INDENT: max_indent = cfg_data[7:0];
					REG_MAX_LINES:  line_limit = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				preset = preset_reports.pop_front();
				if (absorb_word(text_byte, has_byte, end_of_line, predicted))
					expected_reports.push_back(preset.valid ? preset.report : predicted);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_reports.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, expected nothing, got lines_seen %0d",
						$time, lines_seen);
				end else begin
					want = expected_reports.pop_front();
					check_field("keep_going", want.keep_going, keep_going);
					check_field("tab_style", want.tab_style, tab_style);
					check_field("indent_size", want.indent_size, indent_size);
					check_field("lines_seen", want.lines_seen, lines_seen);
				end
			end
		end
	end

	// result side: random stalls, calm stretches and one long hold-off
	initial begin : receiver
		int stall;
		bit calm;
		bit held;
		calm = 1'b0;
		held = 1'b0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 63) == 0)
				calm = !calm;
			stall = calm ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// offer one word and wait for it to be taken
	task automatic send_word(input logic [7:0] ch, input logic has, input logic eol,
			input logic typed, input report_t rpt);
		int      gap;
		preset_t preset;
		if ($urandom_range(0, 63) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		text_byte   <= ch;
		has_byte    <= has;
		end_of_line <= eol;
		preset.valid  = typed;
		preset.report = rpt;
		preset_reports.push_back(preset);
		if (has || eol)
			word_count++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// text after the leading run, closed in one of several ways
	task automatic send_body();
		logic [7:0] body [$];
		int         ending;
		int         last;
		if ($urandom_range(0, 3) == 0)
			body.push_back(8'($urandom_range(0, 255)));
		else
			body.push_back(8'($urandom_range(8'h61, 8'h7A)));
		repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
		ending = $urandom_range(0, 3);
		case (ending)
			0: body.push_back(CH_LF);
			1: begin
				body.push_back(CH_CR);
				body.push_back(CH_LF);
			end
			default: ;
		endcase
		last = body.size() - 1;
		for (int i = 0; i <= last; i++)
			send_word(body[i], 1'b1, (ending != 3) && (i == last), 1'b0, '0);
		if (ending == 3)
			send_word(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
	endtask

	// one line: mostly well-formed indentation, some blank, skipped or noise
	task automatic send_line();
		int kind;
		int depth;
		kind = $urandom_range(0, 99);
		if (kind < 50) begin
			depth = indent_step * $urandom_range(0, 5);
			if ($urandom_range(0, 29) == 0)
				depth = $urandom_range(0, 100);
			else if ($urandom_range(0, 9) == 0)
				depth = depth + 1;
			repeat (depth) send_word(CH_SPACE, 1'b1, 1'b0, 1'b0, '0);
			send_body();
		end else if (kind < 70) begin
			repeat ($urandom_range(1, 4)) send_word(CH_TAB, 1'b1, 1'b0, 1'b0, '0);
			send_body();
		end else if (kind < 80) begin
			case ($urandom_range(0, 3))
				0: send_word(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
				1: send_word(CH_LF, 1'b1, 1'b1, 1'b0, '0);
				2: begin
					send_word(CH_CR, 1'b1, 1'b0, 1'b0, '0);
					send_word(CH_LF, 1'b1, 1'b1, 1'b0, '0);
				end
				default: begin
					repeat ($urandom_range(1, 6)) send_word(CH_SPACE, 1'b1, 1'b0, 1'b0, '0);
					send_word(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
				end
			endcase
		end else if (kind < 90) begin
			// mixed or starred leading run
			case ($urandom_range(0, 2))
				0: begin
					repeat ($urandom_range(1, 3)) send_word(CH_SPACE, 1'b1, 1'b0, 1'b0, '0);
					send_word(CH_TAB, 1'b1, 1'b0, 1'b0, '0);
				end
				1: begin
					repeat ($urandom_range(1, 3)) send_word(CH_TAB, 1'b1, 1'b0, 1'b0, '0);
					send_word(CH_SPACE, 1'b1, 1'b0, 1'b0, '0);
				end
				default: begin
					repeat ($urandom_range(0, 3)) send_word(CH_SPACE, 1'b1, 1'b0, 1'b0, '0);
					send_word(CH_STAR, 1'b1, 1'b0, 1'b0, '0);
				end
			endcase
			send_body();
		end else begin
			repeat ($urandom_range(1, 6))
				send_word(8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0, 1'b0, '0);
		end
	endtask

	task automatic random_lines(input int words);
		int stop_at;
		indent_step = $urandom_range(1, 8);
		stop_at = word_count + words;
		while (word_count < stop_at) begin
			if ($urandom_range(0, 19) == 0)
				send_word(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
			send_line();
		end
	endtask

	// let every pending report come out, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		text_byte   <= '0;
		has_byte    <= 1'b0;
		end_of_line <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_MIN_INDENT;
		cfg_data    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: opening table, then random text
		for (int i = 0; i < $size(OPENING); i++)
			send_word(OPENING[i].text_byte, OPENING[i].has_byte, OPENING[i].end_of_line,
				OPENING[i].typed, OPENING[i].report);
		random_lines(380);
		drain();

		// widest window, a zero line budget, write to the spare index
		write_reg(REG_MIN_INDENT, 16'd0);
		write_reg(REG_MAX_INDENT, 16'd255);
		write_reg(REG_MAX_LINES, 16'd0);
		write_reg(REG_UNUSED, 16'($urandom));
		end_writes();
		random_lines(380);
		drain();

		// min above max: no indent change counted
		write_reg(REG_MIN_INDENT, 16'd255);
		write_reg(REG_MAX_INDENT, 16'd0);
		write_reg(REG_MAX_LINES, 16'hFFFF);
		end_writes();
		random_lines(230);
		drain();

		// line budget runs out during this phase
		write_reg(REG_MIN_INDENT, 16'd1);
		write_reg(REG_MAX_INDENT, 16'd4);
		write_reg(REG_MAX_LINES, 16'(line_total + 15));
		end_writes();
		random_lines(380);
		drain();

		write_reg(REG_MIN_INDENT, 16'($urandom_range(0, 12)));
		write_reg(REG_MAX_INDENT, 16'($urandom_range(0, 24)));
		write_reg(REG_MAX_LINES, 16'($urandom_range(0, 1000)));
		end_writes();
		random_lines(180);
		drain();

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
